// ===== hw/rtl/hbp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbp_pkg
// Shared types and constants of the Huffman bit packer: command codes, the
// input and result words, and the groups passed between pipeline parts.
// ----------------------------------------------------------------------------
package hbp_pkg;

  // Command codes of an input word
  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FINISH = 2'd2
  } hbp_cmd_e;

  // Result kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Widths fixed by the word formats
  localparam int unsigned CodeW     = 32;
  localparam int unsigned LenW      = 6;
  localparam int unsigned BitTotW   = 40;
  localparam int unsigned ByteTotW  = 38;
  localparam int unsigned MaxBytes  = 4;

  // Input word
  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  symbol;
    logic [31:0] code_bits;
    logic [5:0]  code_length;
  } hbp_in_t;

  // Result word
  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [39:0] bit_count;
    logic [37:0] byte_count;
    logic        last;
  } hbp_out_t;

  // Command held in the lookup stage
  typedef struct packed {
    hbp_cmd_e cmd;
    logic     in_range;
  } hbp_req_t;

  // Results caused by one input word, handed to the output serialiser
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [2:0]               nbyte;
    logic                     has_end;
    logic [BitTotW-1:0]       bit_count;
    logic [ByteTotW-1:0]      byte_count;
  } hbp_group_t;

endpackage

// ===== hw/rtl/huffman_bit_packer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_bit_packer_unit
// LSB-first Huffman encoder with a loadable code table.
// ----------------------------------------------------------------------------
// One input word is taken per cycle, when the output is not stalled and the
// word causes at most one result; a word that causes several results (up to
// four packed bytes for a long code, or a padded byte plus the summary for a
// finish) leaves the output register one per cycle while not stalled, and
// input is held off once the lookup stage is full. Table read and lookup stage
// are registered, then the accumulator result in the output register. A load
// followed directly by an encode of the same symbol sees the new entry. The
// table is ready right after reset; entries never loaded read as unused.
// ----------------------------------------------------------------------------
module huffman_bit_packer_unit #(
  parameter int unsigned SYMBOLS      = 256,
  parameter int unsigned MAX_CODE_LEN = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  hbp_pkg::hbp_in_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output hbp_pkg::hbp_out_t out_word_o
);
  import hbp_pkg::*;

  localparam int unsigned AW     = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int unsigned CapLen = (MAX_CODE_LEN < CodeW) ? MAX_CODE_LEN : CodeW;

  hbp_cmd_e   in_cmd;
  logic       in_range;
  logic       in_accept;
  logic [5:0] len_cap;
  logic [32:0] mask_full;
  logic       wr_en;
  logic       rd_en;

  logic       s1_valid_q;
  hbp_req_t   s1_req_q;
  logic       s1_fire;
  logic       ser_ready;

  logic [31:0] rd_bits;
  logic [5:0]  rd_len;
  hbp_group_t  group;

  // Decode the input word and clip the code length
  always_comb begin
    in_cmd    = hbp_cmd_e'(in_word_i.command);
    in_range  = ({1'b0, in_word_i.symbol} < 9'(SYMBOLS));
    len_cap   = (in_word_i.code_length > 6'(CapLen)) ? 6'(CapLen) : in_word_i.code_length;
    mask_full = (33'd1 << len_cap) - 33'd1;
  end

  // Accept when the lookup stage is free or leaves this cycle
  assign s1_fire    = s1_valid_q && ser_ready;
  assign in_stall_o = s1_valid_q && !ser_ready;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign wr_en      = in_accept && in_range && (in_cmd == CMD_LOAD);
  assign rd_en      = in_accept && in_range && (in_cmd == CMD_ENCODE);

  hbp_code_table #(
    .SYMBOLS (SYMBOLS)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (in_word_i.symbol[AW-1:0]),
    .wr_bits_i (in_word_i.code_bits & mask_full[31:0]),
    .wr_len_i  (len_cap),
    .rd_en_i   (rd_en),
    .rd_addr_i (in_word_i.symbol[AW-1:0]),
    .rd_bits_o (rd_bits),
    .rd_len_o  (rd_len)
  );

  // Lookup stage payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_req_q.cmd      <= in_cmd;
      s1_req_q.in_range <= in_range;
    end
  end

  // Lookup stage occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  hbp_packer u_packer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (s1_fire),
    .req_i     (s1_req_q),
    .rd_bits_i (rd_bits),
    .rd_len_i  (rd_len),
    .group_o   (group)
  );

  hbp_out_serializer u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s1_fire),
    .group_i     (group),
    .ready_o     (ser_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== hw/rtl/hbp_code_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbp_code_table
// Code table memory: one entry per symbol holding the masked code bits and
// the code length, with a registered read port and per-entry valid flags so
// that an entry never loaded reads as length zero.
// ----------------------------------------------------------------------------
module hbp_code_table #(
  parameter int unsigned  SYMBOLS = 256,
  localparam int unsigned AW      = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [31:0]   wr_bits_i,
  input  logic [5:0]    wr_len_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [31:0]   rd_bits_o,
  output logic [5:0]    rd_len_o
);
  import hbp_pkg::*;

  logic [CodeW+LenW-1:0] mem [SYMBOLS];
  logic [CodeW+LenW-1:0] rd_q;
  logic [SYMBOLS-1:0]    valid_q;
  logic                  rd_valid_q;

  // Write an entry, read one through a registered port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= {wr_bits_i, wr_len_i};
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  // Track loaded entries
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  // An unloaded entry reads as unused
  assign rd_bits_o = rd_q[CodeW+LenW-1:LenW];
  assign rd_len_o  = rd_valid_q ? rd_q[LenW-1:0] : '0;

endmodule

// ===== hw/rtl/hbp_packer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbp_packer
// Bit accumulator and message counters: appends a looked-up code to the
// pending bits, splits off full bytes and builds the end-of-message summary.
// ----------------------------------------------------------------------------
module hbp_packer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  hbp_pkg::hbp_req_t  req_i,
  input  logic [31:0]        rd_bits_i,
  input  logic [5:0]         rd_len_i,
  output hbp_pkg::hbp_group_t group_o
);
  import hbp_pkg::*;

  logic [7:0]          pbits_q, pbits_d;
  logic [2:0]          pcnt_q, pcnt_d;
  logic [BitTotW-1:0]  bits_q, bits_d;
  logic [ByteTotW-1:0] bytes_q, bytes_d;

  logic [5:0]          len;
  logic [31:0]         code;
  logic [39:0]         acc;
  logic [5:0]          fill;
  logic [2:0]          nfull;
  logic [BitTotW:0]    bits_sum;
  logic [ByteTotW:0]   bytes_sum;
  logic [ByteTotW:0]   bytes_inc;

  // Append the code and split off full bytes
  always_comb begin
    len       = req_i.in_range ? rd_len_i : '0;
    code      = (len == '0) ? '0 : rd_bits_i;
    acc       = ({8'b0, code} << pcnt_q) | {32'b0, pbits_q};
    fill      = {3'b0, pcnt_q} + len;
    nfull     = fill[5:3];
    bits_sum  = {1'b0, bits_q} + {{(BitTotW+1-LenW){1'b0}}, len};
    bytes_sum = {1'b0, bytes_q} + {{(ByteTotW-2){1'b0}}, nfull};
    bytes_inc = {1'b0, bytes_q} + {{ByteTotW{1'b0}}, 1'b1};
  end

  // Next state and result group per command
  always_comb begin
    pbits_d = pbits_q;
    pcnt_d  = pcnt_q;
    bits_d  = bits_q;
    bytes_d = bytes_q;
    group_o = '0;
    unique case (req_i.cmd)
      CMD_ENCODE: begin
        for (int k = 0; k < MaxBytes; k++) begin
          group_o.bytes[k] = acc[8*k +: 8];
        end
        group_o.nbyte = nfull;
        pbits_d = acc[{nfull, 3'b000} +: 8];
        pcnt_d  = fill[2:0];
        bits_d  = bits_sum[BitTotW] ? '1 : bits_sum[BitTotW-1:0];
        bytes_d = bytes_sum[ByteTotW] ? '1 : bytes_sum[ByteTotW-1:0];
      end
      CMD_FINISH: begin
        group_o.has_end    = 1'b1;
        group_o.bit_count  = bits_q;
        group_o.byte_count = bytes_q;
        if (pcnt_q != '0) begin
          group_o.bytes[0]   = pbits_q;
          group_o.nbyte      = 3'd1;
          group_o.byte_count = bytes_inc[ByteTotW] ? '1 : bytes_inc[ByteTotW-1:0];
        end
        pbits_d = '0;
        pcnt_d  = '0;
        bits_d  = '0;
        bytes_d = '0;
      end
      default: begin
        // load and unknown commands leave the message untouched
      end
    endcase
  end

  // Advance the message state when a word leaves the lookup stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pbits_q <= '0;
      pcnt_q  <= '0;
      bits_q  <= '0;
      bytes_q <= '0;
    end else if (fire_i) begin
      pbits_q <= pbits_d;
      pcnt_q  <= pcnt_d;
      bits_q  <= bits_d;
      bytes_q <= bytes_d;
    end
  end

endmodule

// ===== hw/rtl/hbp_out_serializer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbp_out_serializer
// Output register: holds the results of one input word and hands them out
// one word per cycle while not stalled, marking the final one.
// ----------------------------------------------------------------------------
module hbp_out_serializer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  hbp_pkg::hbp_group_t group_i,
  output logic                ready_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hbp_pkg::hbp_out_t   out_word_o
);
  import hbp_pkg::*;

  logic [MaxBytes-1:0][7:0] bytes_q;
  logic [2:0]               nbyte_q;
  logic                     end_q;
  logic [BitTotW-1:0]       tbits_q;
  logic [ByteTotW-1:0]      tbytes_q;
  logic [2:0]               idx_q;

  logic [2:0]               total;
  logic                     busy;
  logic                     is_data;
  logic                     is_last;

  // Decode the word at the current position
  always_comb begin
    total   = nbyte_q + {2'b0, end_q};
    busy    = (idx_q != total);
    is_data = (idx_q < nbyte_q);
    is_last = ((idx_q + 3'd1) == total);

    out_word_o            = '0;
    out_word_o.kind       = is_data ? KIND_DATA : KIND_END;
    out_word_o.data_byte  = is_data ? bytes_q[idx_q[1:0]] : '0;
    out_word_o.bit_count  = is_data ? '0 : tbits_q;
    out_word_o.byte_count = is_data ? '0 : tbytes_q;
    out_word_o.last       = is_last;
  end

  assign out_valid_o = busy;
  assign ready_o     = !busy || (!out_stall_i && is_last);

  // Hold the group payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q  <= group_i.bytes;
      tbits_q  <= group_i.bit_count;
      tbytes_q <= group_i.byte_count;
    end
  end

  // Load a new group or step through the current one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nbyte_q <= '0;
      end_q   <= 1'b0;
      idx_q   <= '0;
    end else if (load_i) begin
      nbyte_q <= group_i.nbyte;
      end_q   <= group_i.has_end;
      idx_q   <= '0;
    end else if (busy && !out_stall_i) begin
      idx_q <= idx_q + 3'd1;
    end
  end

endmodule

// ===== verif/huffman_bit_packer_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_bit_packer_unit_tb
// Self-checking bench for the LSB-first Huffman bit packer. A directed table
// covers empty messages, the longest codes and their cap, zero-length codes,
// ignored code bits, an unknown command and byte-boundary finishes. Random
// messages of loads, encodes, finishes and unknown commands follow. A copy
// of the table, accumulator and totals in the bench predicts each result word
// not fixed by a row. Both sides idle and stall at random, in three phases.
// ----------------------------------------------------------------------------
module huffman_bit_packer_unit_tb;
  import hbp_pkg::*;

  localparam int unsigned SymCount    = 256;
  localparam int unsigned MaxCodeLen  = 32;
  localparam int unsigned CodeCap     = (MaxCodeLen < 32) ? MaxCodeLen : 32;
  localparam logic [1:0]  CmdUnknown  = 2'd3;
  localparam logic [39:0] BitsMax     = '1;
  localparam logic [37:0] BytesMax    = '1;
  localparam int          RandPerPhase = 150;
  localparam int          RxHoldCycles = 300;
  localparam int          SettleCycles = 10;
  localparam int          CycleLimit   = 300000;

  // One row of the directed table; fixed rows carry their single result word
  typedef struct packed {
    hbp_in_t  word;
    logic     fixed;
    hbp_out_t fixed_word;
  } dir_row_t;

  localparam int DirCount = 23;
  localparam dir_row_t DirRows [DirCount] = '{
    // empty message straight after reset
    '{'{CMD_FINISH, 8'd0,   32'h0000_0000, 6'd0},  1'b1,
      '{KIND_END, 8'h00, 40'd0, 38'd0, 1'b1}},
    // longest code, all ones, then a long code capped to the maximum
    '{'{CMD_LOAD,   8'd0,   32'hFFFF_FFFF, 6'd32}, 1'b0, '0},
    '{'{CMD_ENCODE, 8'd0,   32'h0000_0000, 6'd0},  1'b0, '0},
    '{'{CMD_LOAD,   8'd255, 32'h0000_0000, 6'd63}, 1'b0, '0},
    '{'{CMD_ENCODE, 8'd255, 32'hFFFF_FFFF, 6'd63}, 1'b0, '0},
    '{'{CMD_FINISH, 8'd255, 32'hFFFF_FFFF, 6'd63}, 1'b1,
      '{KIND_END, 8'h00, 40'd64, 38'd8, 1'b1}},
    // zero-length code adds nothing
    '{'{CMD_LOAD,   8'd1,   32'hA5A5_A5A5, 6'd0},  1'b0, '0},
    '{'{CMD_ENCODE, 8'd1,   32'h0000_0000, 6'd0},  1'b0, '0},
    // code bits above the length are ignored; a byte fills across symbols
    '{'{CMD_LOAD,   8'd2,   32'hFFFF_FFFD, 6'd3},  1'b0, '0},
    '{'{CMD_ENCODE, 8'd2,   32'h0000_0000, 6'd0},  1'b0, '0},
    '{'{CMD_ENCODE, 8'd2,   32'h0000_0000, 6'd0},  1'b0, '0},
    '{'{CMD_ENCODE, 8'd2,   32'h0000_0000, 6'd0},  1'b0, '0},
    // unknown command does nothing
    '{'{CmdUnknown, 8'd2,   32'hFFFF_FFFF, 6'd63}, 1'b0, '0},
    // finish with a padded partial byte
    '{'{CMD_FINISH, 8'd0,   32'h0000_0000, 6'd0},  1'b0, '0},
    // exactly one byte, then a finish with no partial byte
    '{'{CMD_LOAD,   8'd128, 32'h0000_005A, 6'd8},  1'b0, '0},
    '{'{CMD_ENCODE, 8'd128, 32'h0000_0000, 6'd0},  1'b1,
      '{KIND_DATA, 8'h5A, 40'd0, 38'd0, 1'b1}},
    '{'{CMD_FINISH, 8'd128, 32'h0000_0000, 6'd0},  1'b1,
      '{KIND_END, 8'h00, 40'd8, 38'd1, 1'b1}},
    // reload a symbol mid-message with a capped code, misaligned by one bit
    '{'{CMD_LOAD,   8'd3,   32'h0000_0001, 6'd1},  1'b0, '0},
    '{'{CMD_ENCODE, 8'd3,   32'h0000_0000, 6'd0},  1'b0, '0},
    '{'{CMD_LOAD,   8'd3,   32'hAAAA_AAAA, 6'd33}, 1'b0, '0},
    '{'{CMD_ENCODE, 8'd3,   32'h0000_0000, 6'd0},  1'b0, '0},
    '{'{CMD_ENCODE, 8'd3,   32'h0000_0000, 6'd0},  1'b0, '0},
    '{'{CMD_FINISH, 8'd3,   32'hFFFF_FFFF, 6'd63}, 1'b0, '0}
  };

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  hbp_in_t  in_word   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  hbp_out_t out_word;

  // Bench copy of the code table, accumulator and message totals
  logic [31:0] tbl_code    [SymCount];
  logic [5:0]  tbl_len     [SymCount];
  bit          tbl_written [SymCount];
  logic [7:0]  loaded_syms [$];
  logic [7:0]  acc_bits  = '0;
  logic [2:0]  acc_count = '0;
  logic [39:0] msg_bits  = '0;
  logic [37:0] msg_bytes = '0;

  hbp_out_t caused    [$];
  hbp_out_t words_due [$];

  int tx_idle_pct   = 30;
  int rx_idle_pct   = 64;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;

  huffman_bit_packer_unit #(
    .SYMBOLS      (SymCount),
    .MAX_CODE_LEN (MaxCodeLen)
  ) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Append a full or padded byte and count it towards the message
  task automatic emit_byte(input logic [7:0] b);
    caused.push_back('{KIND_DATA, b, 40'd0, 38'd0, 1'b0});
    if (msg_bytes != BytesMax) msg_bytes++;
  endtask

  // Work out the result words caused by one accepted input word
  task automatic pack_word(input hbp_in_t w);
    logic [5:0]  len;
    logic [31:0] code;
    hbp_out_t    tail;
    int          j;
    caused.delete();
    case (w.command)
      CMD_LOAD: begin
        len = (w.code_length > CodeCap) ? 6'(CodeCap) : w.code_length;
        if (w.symbol < SymCount) begin
          tbl_code[w.symbol] = w.code_bits;
          tbl_len[w.symbol]  = len;
          if (!tbl_written[w.symbol]) begin
            tbl_written[w.symbol] = 1'b1;
            loaded_syms.push_back(w.symbol);
          end
        end
      end
      CMD_ENCODE: begin
        if (w.symbol < SymCount) begin
          code = tbl_code[w.symbol];
          len  = tbl_len[w.symbol];
          // shift code bits in, first bit lowest
          for (j = 0; j < len; j++) begin
            acc_bits[acc_count] = code[j];
            if (acc_count == 3'd7) begin
              emit_byte(acc_bits);
              acc_bits  = '0;
              acc_count = '0;
            end else begin
              acc_count++;
            end
          end
          msg_bits = (BitsMax - msg_bits < 40'(len)) ? BitsMax : msg_bits + 40'(len);
        end
      end
      CMD_FINISH: begin
        if (acc_count != 3'd0) emit_byte(acc_bits);
        caused.push_back('{KIND_END, 8'h00, msg_bits, msg_bytes, 1'b0});
        acc_bits  = '0;
        acc_count = '0;
        msg_bits  = '0;
        msg_bytes = '0;
      end
      default: ;
    endcase
    if (caused.size() > 0) begin
      tail = caused.pop_back();
      tail.last = 1'b1;
      caused.push_back(tail);
    end
  endtask

  // Offer one word, hold it until taken, then queue what it should cause
  task automatic send_word(input hbp_in_t w, input logic fixed, input hbp_out_t fixed_word);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pack_word(w);
    if (fixed) begin
      words_due.push_back(fixed_word);
    end else begin
      foreach (caused[k]) words_due.push_back(caused[k]);
    end
  endtask

  // Stop offering and wait for every outstanding result word
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= RxHoldCycles;
      out_stall   <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Check each accepted result word against the oldest one due
  always @(posedge clk) begin
    hbp_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (words_due.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected word kind=%0d data=%h bits=%0d bytes=%0d last=%0d",
                 $time, out_word.kind, out_word.data_byte, out_word.bit_count,
                 out_word.byte_count, out_word.last);
      end else begin
        want = words_due.pop_front();
        if (out_word.kind !== want.kind || out_word.data_byte !== want.data_byte ||
            out_word.bit_count !== want.bit_count ||
            out_word.byte_count !== want.byte_count || out_word.last !== want.last) begin
          mismatch_count++;
          $display("%0t: expected kind=%0d data=%h bits=%0d bytes=%0d last=%0d",
                   $time, want.kind, want.data_byte, want.bit_count,
                   want.byte_count, want.last);
          $display("%0t:      got kind=%0d data=%h bits=%0d bytes=%0d last=%0d",
                   $time, out_word.kind, out_word.data_byte, out_word.bit_count,
                   out_word.byte_count, out_word.last);
        end
      end
    end
  end

  // Abandon a run that hangs
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Stimulus
  initial begin
    hbp_in_t w;
    int      pick;
    int      roll;
    int      sent;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // walk the directed table
    for (int r = 0; r < DirCount; r++) begin
      send_word(DirRows[r].word, DirRows[r].fixed, DirRows[r].fixed_word);
    end
    wait_drained();

    // random messages over three idling phases
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 30;
          rx_idle_pct = 64;
          hold_requests++;
        end
        1: begin
          tx_idle_pct = 64;
          rx_idle_pct = 30;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < RandPerPhase) begin
        pick          = $urandom_range(99);
        w             = '0;
        w.symbol      = 8'($urandom);
        w.code_bits   = $urandom;
        w.code_length = 6'($urandom);
        if (loaded_syms.size() == 0 || pick < 18) begin
          w.command = CMD_LOAD;
          if ($urandom_range(1) == 1) w.symbol = 8'($urandom_range(15));
          roll = $urandom_range(99);
          if (roll < 5)       w.code_length = 6'd0;
          else if (roll < 75) w.code_length = 6'($urandom_range(12, 1));
          else if (roll < 90) w.code_length = 6'($urandom_range(32, 13));
          else                w.code_length = 6'($urandom_range(63, 33));
        end else if (pick < 90) begin
          // encode only symbols whose entry has been written
          w.command = CMD_ENCODE;
          w.symbol  = loaded_syms[$urandom_range(loaded_syms.size() - 1)];
        end else if (pick < 97) begin
          w.command = CMD_FINISH;
        end else begin
          w.command = CmdUnknown;
        end
        send_word(w, 1'b0, '0);
        if (w.command != CmdUnknown) sent++;
      end
      wait_drained();
    end

    // close the last message and let the block settle
    w = '0;
    w.command = CMD_FINISH;
    send_word(w, 1'b0, '0);
    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== huffman_bit_packer_unit.f =====
hw/rtl/hbp_pkg.sv
hw/rtl/hbp_code_table.sv
hw/rtl/hbp_packer.sv
hw/rtl/hbp_out_serializer.sv
hw/rtl/huffman_bit_packer_unit.sv
verif/huffman_bit_packer_unit_tb.sv
